/* rtl/timed_channel_sequencer_core_assert.svh */
// ----------------------------------------------------------------------------
// timed channel sequencer assertion macros
// shared property forms for the sequencer core checks
// ----------------------------------------------------------------------------
`ifndef TIMED_CHANNEL_SEQUENCER_CORE_ASSERT_SVH
`define TIMED_CHANNEL_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// timed channel sequencer package
// item types, register indexes, mode codes and constants
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int MAX_ROWS_DEF   = 6;
  localparam int CHANNELS_DEF   = 8;
  localparam int ROW_REGS       = 6;
  localparam int MS_PER_MINUTE  = 60000;
  localparam int FULL_PERCENT   = 100;
  localparam int TOTAL_W        = 26;   // 1023 * 60000 fits in 26 bits
  localparam int DIVD_W         = 40;   // elapsed * 100 fits in 39 bits
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BASE  = 3'd2;

  // mode codes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] channel_mask;
    logic [6:0] progress_percent;
    logic       running;
  } out_item_t;

endpackage

/* rtl/timed_channel_sequencer_core.sv */
// ----------------------------------------------------------------------------
// timed channel sequencer core
// timed program over output channels, percent by a serial divider
// ----------------------------------------------------------------------------
// path: start, stop, idle and ignored items pass prep and done to the output register;
// expiry and zero-duration ticks also pass check; saturated ticks pass check and the
// first divider step, running ticks check and all 8 divider steps before done
// flow: one item at a time; a stalled earlier result holds done until it is taken
// a new item is taken while the previous result still waits in the output
// reset: synchronous active-high rst clears start time, registers and state
module timed_channel_sequencer_core #(
  parameter int MAX_ROWS = tcs_pkg::MAX_ROWS_DEF,
  parameter int CHANNELS = tcs_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tcs_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tcs_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcs_pkg::*;

  `include "timed_channel_sequencer_core_assert.svh"

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [9:0]            duration_minutes;
  logic [2:0]            row_count;
  logic [CFG_DATA_W-1:0] row_word [ROW_REGS];

  // program state and working registers
  logic [31:0]        start_time;
  logic [1:0]         mode;
  logic [31:0]        now_ms;
  logic [TOTAL_W-1:0] total;
  logic [DIVD_W-1:0]  rem;
  logic [6:0]         quot;
  logic [2:0]         step;
  logic               sat;
  logic               mask_en;
  logic               res_running;

  // shared subtractor: remainder minus shifted divisor
  logic [DIVD_W:0]   diff;
  logic              borrow;
  logic [DIVD_W-1:0] divisor;
  logic [31:0]       end_time;
  logic [31:0]       elapsed;

  assign divisor  = DIVD_W'(total) << step;
  assign diff     = {1'b0, rem} - {1'b0, divisor};
  assign borrow   = diff[DIVD_W];
  assign end_time = start_time + 32'(total);
  assign elapsed  = now_ms - start_time;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // final percent and channel mask
  logic [6:0] pct_final;
  logic [2:0] rows_eff;
  logic [7:0] mask;

  always_comb begin
    logic [3:0] ch;
    logic [6:0] dly;
    logic [6:0] len;
    logic [7:0] top;
    if (sat || (quot > 7'(FULL_PERCENT))) begin
      pct_final = 7'(FULL_PERCENT);
    end else begin
      pct_final = quot;
    end
    rows_eff = (row_count > 3'(MAX_ROWS)) ? 3'(MAX_ROWS) : row_count;
    mask = '0;
    for (int i = 0; i < ROW_REGS; i++) begin
      dly = row_word[i][6:0];
      len = row_word[i][14:8];
      ch  = row_word[i][19:16];
      top = {1'b0, dly} + {1'b0, len};
      if ((3'(i) < rows_eff) && (ch != 4'd0) && (ch <= 4'(CHANNELS)) &&
          (pct_final >= dly) && ({1'b0, pct_final} < top)) begin
        mask = mask | (8'd1 << (ch - 4'd1));
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_minutes <= '0;
      row_count        <= '0;
      for (int i = 0; i < ROW_REGS; i++) begin
        row_word[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DURATION:  duration_minutes <= cfg_data[9:0];
        REG_ROW_COUNT: row_count <= cfg_data[2:0];
        default:       row_word[cfg_index - REG_ROW_BASE] <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      start_time <= '0;
      out_valid  <= 1'b0;
    end else begin
      // drop a taken result unless done puts out the next one
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode   <= in_data.mode;
            now_ms <= in_data.now_ms;
            state  <= ST_PREP;
          end
        end
        ST_PREP: begin
          quot    <= '0;
          sat     <= 1'b0;
          mask_en <= 1'b0;
          total   <= TOTAL_W'(duration_minutes) * TOTAL_W'(MS_PER_MINUTE);
          rem     <= DIVD_W'(elapsed) * DIVD_W'(FULL_PERCENT);
          state   <= ST_DONE;
          unique case (mode)
            MODE_START: begin
              start_time  <= now_ms;
              res_running <= (now_ms != 32'd0);
            end
            MODE_STOP: begin
              start_time  <= '0;
              res_running <= 1'b0;
            end
            MODE_TICK: begin
              res_running <= (start_time != 32'd0);
              if (start_time != 32'd0) begin
                state <= ST_CHECK;
              end
            end
            default: res_running <= (start_time != 32'd0);
          endcase
        end
        ST_CHECK: begin
          if (now_ms > end_time) begin
            start_time  <= '0;
            res_running <= 1'b0;
            state       <= ST_DONE;
          end else if (total == '0) begin
            state <= ST_DONE;
          end else begin
            mask_en <= 1'b1;
            step    <= 3'd7;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == 3'd7) begin
            // quotient of 128 or more saturates
            if (!borrow) begin
              sat   <= 1'b1;
              state <= ST_DONE;
            end else begin
              step <= step - 3'd1;
            end
          end else begin
            if (!borrow) begin
              rem        <= diff[DIVD_W-1:0];
              quot[step] <= 1'b1;
            end
            if (step == 3'd0) begin
              state <= ST_DONE;
            end else begin
              step <= step - 3'd1;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid                 <= 1'b1;
            out_data.channel_mask     <= mask_en ? mask : 8'd0;
            out_data.progress_percent <= mask_en ? pct_final : 7'd0;
            out_data.running          <= res_running;
            state                     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `TCS_ASSERT_NOW(a_pct_range, clk, rst, out_valid,
                  out_data.progress_percent <= 7'(FULL_PERCENT),
                  "percent above full scale")
  `TCS_ASSERT_NOW(a_idle_mask, clk, rst, out_valid && !out_data.running,
                  out_data.channel_mask == 8'd0, "channel on while not running")
  `TCS_ASSERT_NOW(a_div_total, clk, rst, state == ST_DIV, total != '0,
                  "divider running with zero total")
  `TCS_ASSERT_NEXT(a_accept_prep, clk, rst, in_valid && !in_stall,
                   state == ST_PREP, "accepted item did not enter prep")

endmodule

/* bench/timed_channel_sequencer_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed channel sequencer core testbench
// drives start, stop, tick and ignored items against a local predictor of the program
// timer and channel windows, checks every result in order, with random gaps
// on the sender and a random stall pattern on the receiver
// ----------------------------------------------------------------------------
module timed_channel_sequencer_core_tb;
  import tcs_pkg::*;

  // mode code the block takes and ignores
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state: program start time and register copies
  logic [31:0] run_start;
  logic [9:0]  prog_minutes;
  logic [2:0]  prog_rows;
  logic [19:0] row_words [ROW_REGS];

  out_item_t expected_results [$];
  int        mismatches;
  int        items_sent;

  // sender and receiver pacing
  int gap_max;
  int burst_max;
  int burst_left;
  int stall_duty;
  int stall_run_max;
  int stall_left;
  logic hold_out;

  timed_channel_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // expected result of one item, advancing the program timer
  function automatic out_item_t program_step(input in_item_t item);
    out_item_t   res;
    logic [31:0] total;
    logic [31:0] finish;
    logic [31:0] elapsed;
    logic [63:0] pct;
    logic [19:0] w;
    int          rows;
    int          dly;
    int          len;
    int          ch;
    res = '0;
    case (item.mode)
      MODE_START: run_start = item.now_ms;
      MODE_STOP:  run_start = '0;
      MODE_TICK: begin
        if (run_start != 0) begin
          total  = 32'(prog_minutes) * 32'(MS_PER_MINUTE);
          finish = run_start + total;
          if (item.now_ms > finish) begin
            run_start = '0;
          end else if (total != 0) begin
            elapsed = item.now_ms - run_start;
            pct = (64'(elapsed) * 64'(FULL_PERCENT)) / 64'(total);
            if (pct > FULL_PERCENT) pct = FULL_PERCENT;
            res.progress_percent = pct[6:0];
            rows = (prog_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(prog_rows);
            for (int i = 0; i < rows; i++) begin
              w   = row_words[i];
              dly = int'(w[6:0]);
              len = int'(w[14:8]);
              ch  = int'(w[19:16]);
              if (ch != 0 && ch <= CHANNELS_DEF && int'(pct) >= dly && int'(pct) < dly + len)
                res.channel_mask[3'(ch - 1)] = 1'b1;
            end
          end
        end
      end
      default: ;  // ignored mode keeps the state
    endcase
    res.running = (run_start != 0);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 200) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // receiver stall pattern: runs of stall or no stall of random length
  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
      hold_out   = 1'b0;
    end else if (stall_left == 0) begin
      stall_left = $urandom_range(1, stall_run_max);
      hold_out = (stall_duty != 0) && ($urandom_range(1, 100) <= stall_duty);
    end else begin
      stall_left--;
    end
    out_stall <= hold_out;
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_data.channel_mask !== want.channel_mask)
          report_mismatch($sformatf("channel_mask got %h want %h",
                                    out_data.channel_mask, want.channel_mask));
        if (out_data.progress_percent !== want.progress_percent)
          report_mismatch($sformatf("progress_percent got %0d want %0d",
                                    out_data.progress_percent, want.progress_percent));
        if (out_data.running !== want.running)
          report_mismatch($sformatf("running got %b want %b",
                                    out_data.running, want.running));
      end
    end
  end

  task automatic set_pacing(input int gap, input int burst, input int duty, input int run);
    gap_max       = gap;
    burst_max     = burst;
    burst_left    = 0;
    stall_duty    = duty;
    stall_run_max = run;
  endtask

  // send one item, drop valid once taken, then idle between bursts
  task automatic send_item(input logic [1:0] mode, input logic [31:0] now);
    int gap;
    @(negedge clk);
    in_valid       = 1'b1;
    in_data.mode   = mode;
    in_data.now_ms = now;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(program_step(in_data));
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
    if (gap_max > 0) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, gap_max);
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(0, burst_max);
      end
    end
  endtask

  // hold the sender until every expected result has come
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DURATION:  prog_minutes = data[9:0];
      REG_ROW_COUNT: prog_rows    = data[2:0];
      default:       row_words[idx - REG_ROW_BASE] = data;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // write all registers, with random bits above the duration and row count fields
  task automatic load_program(input logic [9:0] minutes, input logic [2:0] rows,
                              input logic [5:0][19:0] words);
    wait_idle();
    write_reg(REG_DURATION, {10'($urandom), minutes});
    write_reg(REG_ROW_COUNT, {17'($urandom), rows});
    for (int i = 0; i < ROW_REGS; i++)
      write_reg(REG_ROW_BASE + CFG_IDX_W'(i), words[i]);
  endtask

  function automatic logic [19:0] random_row();
    logic [3:0] ch;
    logic [6:0] dly;
    logic [6:0] len;
    ch  = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8)) : 4'($urandom);
    dly = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 100)) : 7'($urandom);
    len = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 60)) : 7'($urandom);
    return {ch, 1'($urandom), len, 1'($urandom), dly};
  endfunction

  // idle block right after reset: every mode, zero start, zero duration
  task automatic test_reset_idle();
    send_item(MODE_TICK, 32'h0000_0000);
    send_item(MODE_TICK, 32'hFFFF_FFFF);
    send_item(MODE_IGNORED, $urandom);
    send_item(MODE_STOP, $urandom);
    send_item(MODE_START, 32'h0000_0000);
    send_item(MODE_TICK, 32'd123);
    send_item(MODE_START, 32'd5);
    send_item(MODE_IGNORED, 32'd7);
    send_item(MODE_TICK, 32'd5);
    send_item(MODE_TICK, 32'd6);
  endtask

  // one minute program, saturated row count, ignored channels, window edges
  task automatic test_row_windows();
    logic [5:0][19:0] words;
    words[0] = {4'd1, 1'b0, 7'd100, 1'b0, 7'd0};
    words[1] = {4'd8, 1'b1, 7'd1, 1'b1, 7'd50};
    words[2] = {4'd0, 1'b0, 7'd127, 1'b0, 7'd0};
    words[3] = {4'd9, 1'b0, 7'd100, 1'b0, 7'd0};
    words[4] = 20'hFFFFF;
    words[5] = {4'd2, 1'b0, 7'd127, 1'b0, 7'd100};
    load_program(10'd1, 3'd7, words);
    send_item(MODE_START, 32'd1000);
    send_item(MODE_TICK, 32'd1000);
    send_item(MODE_TICK, 32'd31000);
    send_item(MODE_TICK, 32'd61000);
    send_item(MODE_TICK, 32'd61001);
  endtask

  // end time past the wrap, and a tick before the start time
  task automatic test_wrap_saturation();
    send_item(MODE_START, 32'hFFFF_FFF0);
    send_item(MODE_TICK, 32'h0000_0010);
    send_item(MODE_TICK, 32'hFFFF_FFFF);
    send_item(MODE_START, 32'd1000);
    send_item(MODE_TICK, 32'd999);
    send_item(MODE_STOP, 32'd2000);
  endtask

  // longest program, right at its end and just past it
  task automatic test_max_duration();
    logic [5:0][19:0] words;
    logic [31:0]      total;
    words    = '0;
    words[0] = {4'd3, 1'b0, 7'd1, 1'b0, 7'd99};
    load_program(10'd1023, 3'd1, words);
    total = 32'd1023 * 32'(MS_PER_MINUTE);
    send_item(MODE_START, 32'h8000_0000);
    send_item(MODE_TICK, 32'h8000_0000 + total);
    send_item(MODE_TICK, 32'h8000_0001 + total);
  endtask

  // random programs: start, ticks across the window, stops and noise
  task automatic test_random_programs();
    logic [5:0][19:0] words;
    logic [9:0]       minutes;
    logic [31:0]      total;
    logic [31:0]      span;
    logic [31:0]      t0;
    logic [31:0]      off;
    int               target;
    int               ticks;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       minutes = 10'd1023;
        2:       minutes = 10'd0;
        3:       minutes = 10'd1;
        default: minutes = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(1, 5))
                                                       : 10'($urandom);
      endcase
      for (int i = 0; i < ROW_REGS; i++) words[i] = random_row();
      load_program(minutes, 3'($urandom), words);
      if (phase == 0) set_pacing(0, 0, 0, 1);
      else set_pacing($urandom_range(1, 12), $urandom_range(0, 8),
                      $urandom_range(10, 70), $urandom_range(1, 8));
      total  = 32'(minutes) * 32'(MS_PER_MINUTE);
      span   = total + total / 8 + 2;
      target = items_sent + 150;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 85) begin
          case ($urandom_range(0, 9))
            0:       t0 = 32'h0;
            1:       t0 = 32'hFFFF_FFFF - $urandom_range(0, total);
            default: t0 = $urandom;
          endcase
          send_item(MODE_START, t0);
          ticks = $urandom_range(2, 10);
          for (int k = 0; k < ticks; k++) begin
            case ($urandom_range(0, 19))
              0:       off = total;
              1:       off = total + 1;
              2:       off = $urandom;
              default: off = $urandom_range(0, span);
            endcase
            if ($urandom_range(0, 29) == 0) send_item(MODE_STOP, $urandom);
            else if ($urandom_range(0, 29) == 0) send_item(MODE_IGNORED, t0 + off);
            else send_item(MODE_TICK, t0 + off);
          end
          if ($urandom_range(0, 29) == 0) wait_idle();
        end else begin
          send_item(2'($urandom), $urandom);
        end
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    run_start = '0;
    prog_minutes = '0;
    prog_rows = '0;
    for (int i = 0; i < ROW_REGS; i++) row_words[i] = '0;
    mismatches = 0;
    items_sent = 0;
    set_pacing(4, 3, 30, 4);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_idle();
    test_row_windows();
    test_wrap_saturation();
    test_max_duration();
    test_random_programs();

    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tcs_pkg.sv
rtl/timed_channel_sequencer_core.sv
bench/timed_channel_sequencer_core_tb.sv
